// File: rtl/core/signed_bitfield_rect_parser_core_macros.svh
// Assertion macros for the signed bit-field rectangle parser checker.
// Each macro expects a signal named clk, and SBRP_ASSERT also rst_n, in the scope that uses it.
`ifndef SIGNED_BITFIELD_RECT_PARSER_CORE_MACROS_SVH
`define SIGNED_BITFIELD_RECT_PARSER_CORE_MACROS_SVH

// Concurrent check on the rising clock, muted while reset is held.
`define SBRP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check on the rising clock that also runs during reset.
`define SBRP_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/sbrp_pkg.sv
// Shared types and constants for the signed bit-field rectangle parser.
// No dependencies; every other file of the block but the macros header imports this package.
`default_nettype none

package sbrp_pkg;

  // Width of each decoded field and of the byte count on the result side.
  localparam int unsigned VAL_W = 31;
  localparam int unsigned CNT_W = 5;

  // Largest byte count the result can report; longer records saturate to it.
  localparam int unsigned CNT_MAX = 31;

  // Entries in each of the two decoupling queues.
  localparam logic [1:0] Q_DEPTH = 2'd2;

  // Fields kept in registers until the record's last byte; the fourth
  // field always completes in that last byte.
  localparam logic [2:0] NUM_STORED = 3'd3;

  // Saturation limits for fields wider than the result.
  localparam logic [VAL_W-1:0] POS_LIMIT = 31'h3FFF_FFFF;
  localparam logic [VAL_W-1:0] NEG_LIMIT = 31'h4000_0000;

  // One stream byte after classification by the front end.
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       hdr_fits;   // as a header, the whole record fits in this byte
  } byte_item_t;

  // One finished record.
  typedef struct packed {
    logic signed [VAL_W-1:0] x_min;
    logic signed [VAL_W-1:0] x_max;
    logic signed [VAL_W-1:0] y_min;
    logic signed [VAL_W-1:0] y_max;
    logic [CNT_W-1:0]        record_bytes;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/sbrp_front.sv
// Front end: accepts stream bytes, pre-decodes each as a possible header,
// and holds them in a two-entry queue for the unpacker. Uses sbrp_pkg.
`default_nettype none

module sbrp_front #(
  parameter int unsigned HDR_W = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           push_data,
  input  logic                 push_restart,
  input  logic                 push,
  output logic                 full,
  output logic                 deq_valid,
  output sbrp_pkg::byte_item_t deq_item,
  output logic [HDR_W+1:0]     deq_need,
  input  logic                 deq_take
);
  import sbrp_pkg::*;

  localparam int unsigned NEED_W = HDR_W + 2;
  localparam logic [NEED_W-1:0] AVAIL = NEED_W'(8 - HDR_W);

  byte_item_t        item_mem_r [2];
  logic [NEED_W-1:0] need_mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [HDR_W-1:0]  hdr_n;
  logic [NEED_W-1:0] hdr_need;
  byte_item_t        cls_item;
  logic              do_push, do_pop;

  // Read the byte as if it opened a record: field width and field bits.
  always_comb begin
    hdr_n             = push_data[7 -: HDR_W];
    hdr_need          = {hdr_n, 2'b00};
    cls_item.data     = push_data;
    cls_item.restart  = push_restart;
    cls_item.hdr_fits = (hdr_need <= AVAIL);
  end

  // Queue handshake.
  assign full      = (cnt_r == Q_DEPTH);
  assign deq_valid = (cnt_r != 2'd0);
  assign do_push   = push && !full;
  assign do_pop    = deq_take && deq_valid;
  assign deq_item  = item_mem_r[rd_ptr_r];
  assign deq_need  = need_mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      item_mem_r[wr_ptr_r] <= cls_item;
      need_mem_r[wr_ptr_r] <= hdr_need;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sbrp_unpack.sv
// Back end: consumes one classified byte per cycle while the result queue has room, extracts
// up to eight field bits, sign-extends finished fields and emits records. Uses sbrp_pkg.
`default_nettype none

module sbrp_unpack #(
  parameter int unsigned HDR_W = 5
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  sbrp_pkg::byte_item_t in_item,
  input  logic [HDR_W+1:0]     in_need,
  output logic                 in_take,
  input  logic                 res_room,
  output logic                 res_push,
  output sbrp_pkg::result_t    res_data
);
  import sbrp_pkg::*;

  localparam int unsigned NEED_W = HDR_W + 2;
  localparam int unsigned AVAIL  = 8 - HDR_W;
  localparam int unsigned MAXB   = (4 * (2 ** HDR_W - 1) + HDR_W + 7) / 8;
  localparam int unsigned BCW    = $clog2(MAXB + 1);

  // Record control state.
  logic              seen_r, seen_nxt;
  logic [HDR_W-1:0]  n_r, n_nxt;
  logic [HDR_W-1:0]  t_r, t_nxt;
  logic [2:0]        fnum_r, fnum_nxt;
  logic [NEED_W-1:0] rem_r, rem_nxt;
  logic [BCW-1:0]    bytes_r, bytes_nxt;
  // Field being assembled and the finished fields.
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic              s_r, s_nxt;
  logic              ovf_r, ovf_nxt;
  logic [VAL_W-1:0]  f_r [3];
  logic [VAL_W-1:0]  f_nxt [3];
  logic [VAL_W-1:0]  last_val;
  logic [VAL_W-1:0]  val;
  logic              hdr, done, b, bit_take;
  logic [3:0]        first, nbits;
  logic [4:0]        lim;

  assign in_take = in_valid && res_room;

  // Byte-level bookkeeping, then the unrolled walk over the byte's bits.
  always_comb begin
    hdr       = in_item.restart || !seen_r;
    n_nxt     = n_r;
    t_nxt     = t_r;
    fnum_nxt  = fnum_r;
    acc_nxt   = acc_r;
    s_nxt     = s_r;
    ovf_nxt   = ovf_r;
    f_nxt     = f_r;
    last_val  = '0;
    val       = '0;
    b         = 1'b0;
    bit_take  = 1'b0;
    if (hdr) begin
      first     = 4'(HDR_W);
      done      = in_item.hdr_fits;
      nbits     = done ? in_need[3:0] : 4'(AVAIL);
      rem_nxt   = in_need - NEED_W'(AVAIL);
      n_nxt     = in_item.data[7 -: HDR_W];
      t_nxt     = '0;
      fnum_nxt  = '0;
      bytes_nxt = BCW'(1);
      f_nxt[0]  = '0;
      f_nxt[1]  = '0;
      f_nxt[2]  = '0;
    end else begin
      first     = 4'd0;
      done      = (rem_r <= NEED_W'(8));
      nbits     = done ? rem_r[3:0] : 4'd8;
      rem_nxt   = rem_r - NEED_W'(8);
      bytes_nxt = bytes_r + BCW'(1);
    end
    lim = 5'(first) + 5'(nbits);

    // Most significant bit first; only bits inside the record are taken.
    for (int i = 0; i < 8; i++) begin
      b        = in_item.data[7 - i];
      bit_take = (4'(i) >= first) && (5'(i) < lim);
      if (bit_take) begin
        if (t_nxt == '0) begin
          s_nxt   = b;
          acc_nxt = {VAL_W{b}};
          ovf_nxt = 1'b0;
        end else begin
          ovf_nxt = ovf_nxt | (acc_nxt[VAL_W-1] != s_nxt);
          acc_nxt = {acc_nxt[VAL_W-2:0], b};
        end
        t_nxt = t_nxt + HDR_W'(1);
        if (t_nxt == n_nxt) begin
          // Field complete: saturate if it does not fit the result width.
          if (ovf_nxt || (acc_nxt[VAL_W-1] != s_nxt)) begin
            val = s_nxt ? NEG_LIMIT : POS_LIMIT;
          end else begin
            val = acc_nxt;
          end
          if (fnum_nxt < NUM_STORED) begin
            f_nxt[fnum_nxt[1:0]] = val;
          end else begin
            last_val = val;
          end
          fnum_nxt = fnum_nxt + 3'd1;
          t_nxt    = '0;
        end
      end
    end

    seen_nxt = !done;
    if (done) begin
      t_nxt     = '0;
      fnum_nxt  = '0;
      bytes_nxt = '0;
    end
  end

  // Result for a record whose last byte is being consumed.
  always_comb begin
    res_push              = in_take && done;
    res_data.x_min        = f_nxt[0];
    res_data.x_max        = f_nxt[1];
    res_data.y_min        = f_nxt[2];
    res_data.y_max        = last_val;
    res_data.record_bytes = (32'(bytes_r) + 32'd1 > 32'(CNT_MAX) && !hdr) ?
                            CNT_W'(CNT_MAX) :
                            (hdr ? CNT_W'(1) : CNT_W'(bytes_r + BCW'(1)));
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= 1'b0;
      n_r     <= '0;
      t_r     <= '0;
      fnum_r  <= '0;
      rem_r   <= '0;
      bytes_r <= '0;
    end else if (in_take) begin
      seen_r  <= seen_nxt;
      n_r     <= n_nxt;
      t_r     <= t_nxt;
      fnum_r  <= fnum_nxt;
      rem_r   <= rem_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  // Field payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      acc_r <= acc_nxt;
      s_r   <= s_nxt;
      ovf_r <= ovf_nxt;
      f_r   <= f_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/sbrp_resq.sv
// Result queue: two finished records waiting for the consumer.
// Uses sbrp_pkg for the record type.
`default_nettype none

module sbrp_resq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sbrp_pkg::result_t push_data,
  output logic              room,
  output logic              empty,
  output sbrp_pkg::result_t head,
  input  logic              pop
);
  import sbrp_pkg::*;

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  // Handshake on both sides.
  assign room    = (cnt_r != Q_DEPTH);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && room;
  assign do_pop  = pop && !empty;
  assign head    = mem_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Record storage carries no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/signed_bitfield_rect_parser_core.sv
// Signed bit-field rectangle parser. Bytes enter MSB first through a queue
// port (push/full); each record is a WIDTH_HEADER_BITS-bit width N followed
// by four signed N-bit fields, and one record leaves through a queue port
// (empty/pop) once its last byte is consumed, with padding bits ignored and
// fields wider than 31 bits saturated. The block takes one byte per clock
// sustained while the consumer keeps popping. A record shows on the result
// ports once it is written into the result queue: its last byte is first
// registered in the front queue, and the unpacker, whose eight-bit
// field extraction handles a whole byte in one pass, writes the record into
// the result queue as it takes that byte. Both queues hold two words, and a full
// queue takes no new word in the cycle it is popped. The unpacker stalls on
// every byte while two records wait, so a stalled consumer raises in_full
// once two records are waiting and two more bytes sit in the front queue.
// Asserting in_restart drops any partial record and treats that byte as a
// new header. No clearing pass is needed after reset.
// Depends on sbrp_pkg, sbrp_front, sbrp_unpack and sbrp_resq.
`default_nettype none

module signed_bitfield_rect_parser_core #(
  parameter int unsigned WIDTH_HEADER_BITS = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [7:0]                          in_data_byte,
  input  logic                                in_restart,
  input  logic                                in_push,
  output logic                                in_full,
  output logic signed [sbrp_pkg::VAL_W-1:0]   out_x_min,
  output logic signed [sbrp_pkg::VAL_W-1:0]   out_x_max,
  output logic signed [sbrp_pkg::VAL_W-1:0]   out_y_min,
  output logic signed [sbrp_pkg::VAL_W-1:0]   out_y_max,
  output logic [sbrp_pkg::CNT_W-1:0]          out_record_bytes,
  output logic                                out_empty,
  input  logic                                out_pop
);
  import sbrp_pkg::*;

  byte_item_t                 q_item;
  logic [WIDTH_HEADER_BITS+1:0] q_need;
  logic                       q_valid, q_take;
  logic                       res_room, res_push;
  result_t                    res_data, res_head;

  // Front end with its two-word queue.
  sbrp_front #(
    .HDR_W(WIDTH_HEADER_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push_data    (in_data_byte),
    .push_restart (in_restart),
    .push         (in_push),
    .full         (in_full),
    .deq_valid    (q_valid),
    .deq_item     (q_item),
    .deq_need     (q_need),
    .deq_take     (q_take)
  );

  // Bit extraction and field assembly.
  sbrp_unpack #(
    .HDR_W(WIDTH_HEADER_BITS)
  ) u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (q_valid),
    .in_item  (q_item),
    .in_need  (q_need),
    .in_take  (q_take),
    .res_room (res_room),
    .res_push (res_push),
    .res_data (res_data)
  );

  // Result queue toward the consumer.
  sbrp_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .room      (res_room),
    .empty     (out_empty),
    .head      (res_head),
    .pop       (out_pop)
  );

  assign out_x_min        = res_head.x_min;
  assign out_x_max        = res_head.x_max;
  assign out_y_min        = res_head.y_min;
  assign out_y_max        = res_head.y_max;
  assign out_record_bytes = res_head.record_bytes;

endmodule

`default_nettype wire

// File: rtl/core/sbrp_checker.sv
// Port-level checks for signed_bitfield_rect_parser_core, bound to the top.
// Depends on the assertion macros header and sbrp_pkg.
`default_nettype none
`include "signed_bitfield_rect_parser_core_macros.svh"

module sbrp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_full,
  input logic signed [sbrp_pkg::VAL_W-1:0] out_x_min,
  input logic signed [sbrp_pkg::VAL_W-1:0] out_x_max,
  input logic signed [sbrp_pkg::VAL_W-1:0] out_y_min,
  input logic signed [sbrp_pkg::VAL_W-1:0] out_y_max,
  input logic [sbrp_pkg::CNT_W-1:0]        out_record_bytes,
  input logic                              out_empty,
  input logic                              out_pop
);
  import sbrp_pkg::*;

  logic one_byte, tiny_fields;

  // A record that fits in one byte has fields of at most one bit: 0 or -1.
  assign one_byte    = !out_empty && (out_record_bytes == CNT_W'(1));
  assign tiny_fields = ((out_x_min == '0) || (out_x_min == '1)) &&
                       ((out_x_max == '0) || (out_x_max == '1)) &&
                       ((out_y_min == '0) || (out_y_min == '1)) &&
                       ((out_y_max == '0) || (out_y_max == '1));

  // The waiting word stays on the result ports, unchanged.
  sequence head_kept;
    !out_empty && $stable(out_x_min) && $stable(out_x_max) &&
    $stable(out_y_min) && $stable(out_y_max) && $stable(out_record_bytes);
  endsequence

  `SBRP_ASSERT_ANY(a_reset_clears, !rst_n |=> out_empty && !in_full, "queues not empty after reset")
  `SBRP_ASSERT(a_count_nonzero, !out_empty |-> out_record_bytes != '0, "record of zero bytes")
  `SBRP_ASSERT(a_one_byte_fields, one_byte |-> tiny_fields, "one-byte record with wide field")
  `SBRP_ASSERT(a_head_stall, !out_empty && !out_pop |=> head_kept, "head changed")

endmodule

bind signed_bitfield_rect_parser_core sbrp_checker u_sbrp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_x_min        (out_x_min),
  .out_x_max        (out_x_max),
  .out_y_min        (out_y_min),
  .out_y_max        (out_y_max),
  .out_record_bytes (out_record_bytes),
  .out_empty        (out_empty),
  .out_pop          (out_pop)
);

`default_nettype wire
